// ===== sv/mtfrt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtfrt_pkg
// Shared types and constants for the move-to-front rank table.
// ----------------------------------------------------------------------------
package mtfrt_pkg;

	// field widths of one item
	localparam int ACT_W       = 2;
	localparam int COL_W       = 6;
	localparam int POS_W       = 17;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 24;

	// action codes carried in the input item
	typedef enum logic [ACT_W-1:0] {
		ACT_CLEAR = 2'd0,
		ACT_LOAD  = 2'd1,
		ACT_QUERY = 2'd2,
		ACT_NONE  = 2'd3
	} mtfrt_act_t;

	// controller to datapath
	typedef struct packed {
		logic latch;   // capture the incoming item and its selected position
		logic commit;  // apply the captured item to the table
	} mtfrt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic query_pend;  // captured item is a valid query with a result
		logic out_busy;    // output register holds an item not taken this cycle
	} mtfrt_sts_t;

endpackage

// ===== sv/move_to_front_rank_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// move_to_front_rank_table
// Topmost position of each colour in a deck kept in move-to-front order.
// ----------------------------------------------------------------------------
// Each item passes through the IDLE and EXEC states: in the cycle it is
// accepted the queried colour's position is read from its cell (or count+1
// when absent) and captured; in EXEC that position is broadcast to every cell,
// which compares and increments in parallel, or the load or clear is applied.
// A query holds in EXEC while an earlier result still waits in the output
// register. A clear empties the whole table in a single commit, and reset leaves
// the table empty with no clearing pass. Invalid colours and unused actions
// are absorbed with no result.
module move_to_front_rank_table #(
	parameter int NUM_COLORS = 50,
	parameter int MAX_CARDS  = 65535
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [mtfrt_pkg::IN_TDATA_W-1:0]     s_tdata,   // action[1:0], color[7:2]
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [mtfrt_pkg::OUT_TDATA_W-1:0]    m_tdata    // position[16:0], zero pad
);
	import mtfrt_pkg::*;

	mtfrt_cmd_t cmd;
	mtfrt_sts_t sts;

	// sequence items
	mtfrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// table and output register
	mtfrt_dp #(
		.NUM_COLORS (NUM_COLORS),
		.MAX_CARDS  (MAX_CARDS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== sv/mtfrt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtfrt_ctrl
// Two-state controller: take an item, then commit it once the output side
// can take any result it makes.
// ----------------------------------------------------------------------------
module mtfrt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  mtfrt_pkg::mtfrt_sts_t sts,
	output mtfrt_pkg::mtfrt_cmd_t cmd
);
	import mtfrt_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;

	// accept only between items; commit unless a result would overwrite one
	assign s_tready   = (state_q == ST_IDLE);
	assign cmd.latch  = (state_q == ST_IDLE) && s_tvalid;
	assign cmd.commit = (state_q == ST_EXEC) && !(sts.query_pend && sts.out_busy);

	// advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.latch) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (cmd.commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/mtfrt_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtfrt_dp
// Rank table datapath: per-colour position cells with parallel
// compare-and-increment, card counter and output register.
// ----------------------------------------------------------------------------
module mtfrt_dp #(
	parameter int NUM_COLORS = 50,
	parameter int MAX_CARDS  = 65535
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mtfrt_pkg::mtfrt_cmd_t                cmd,
	output mtfrt_pkg::mtfrt_sts_t                sts,
	input  logic [mtfrt_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [mtfrt_pkg::OUT_TDATA_W-1:0]    m_tdata
);
	import mtfrt_pkg::*;

	localparam int CW   = $clog2(NUM_COLORS);
	localparam int CNTW = $clog2(MAX_CARDS + 1);
	localparam int PW   = $clog2(MAX_CARDS + 2);
	localparam int XW   = CW + COL_W;
	localparam logic [CNTW-1:0] CNT_MAX = CNTW'(MAX_CARDS);
	localparam logic [XW-1:0]   COL_MAX = XW'(NUM_COLORS);

	// table cells
	logic [PW-1:0]         top_q [NUM_COLORS];
	logic [NUM_COLORS-1:0] present_q;
	logic [CNTW-1:0]       count_q;

	// captured item
	mtfrt_act_t    act_s1;
	logic          ok_s1;
	logic [CW-1:0] idx_s1;
	logic [PW-1:0] pos_s1;

	// output register
	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	// decode incoming item
	mtfrt_act_t    in_act;
	logic [XW-1:0] in_col;
	logic [XW-1:0] in_col_m1;
	logic [CW-1:0] in_idx;
	logic          in_ok;
	logic [PW-1:0] count_p1;
	logic [PW-1:0] in_pos;

	assign in_act    = mtfrt_act_t'(s_tdata[ACT_W-1:0]);
	assign in_col    = XW'(s_tdata[ACT_W +: COL_W]);
	assign in_col_m1 = in_col - XW'(1);
	assign in_idx    = in_col_m1[CW-1:0];
	assign in_ok     = (in_col != '0) && (in_col <= COL_MAX);
	assign count_p1  = PW'(count_q) + PW'(1);
	assign in_pos    = present_q[in_idx] ? top_q[in_idx] : count_p1;

	// result, masked to the output field width
	logic [PW+POS_W-1:0] pos_ext;
	assign pos_ext = {{POS_W{1'b0}}, pos_s1};

	logic query_ok;
	logic load_ok;
	assign query_ok = (act_s1 == ACT_QUERY) && ok_s1;
	assign load_ok  = (act_s1 == ACT_LOAD) && ok_s1 && (count_q != CNT_MAX);

	assign sts.query_pend = query_ok;
	assign sts.out_busy   = m_tvalid_q && !m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// capture item and its selected position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= ACT_NONE;
			ok_s1  <= 1'b0;
		end else if (cmd.latch) begin
			act_s1 <= in_act;
			ok_s1  <= in_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			idx_s1 <= in_idx;
			pos_s1 <= in_pos;
		end
	end

	// card counter and presence marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			present_q <= '0;
		end else if (cmd.commit) begin
			if (act_s1 == ACT_CLEAR) begin
				count_q   <= '0;
				present_q <= '0;
			end else if (load_ok) begin
				count_q           <= count_q + CNTW'(1);
				present_q[idx_s1] <= 1'b1;
			end else if (query_ok) begin
				present_q[idx_s1] <= 1'b1;
			end
		end
	end

	// position cells: record on load, compare-and-increment on query
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (load_ok && !present_q[idx_s1]) begin
				top_q[idx_s1] <= count_p1;
			end else if (query_ok) begin
				for (int c = 0; c < NUM_COLORS; c++) begin
					if (CW'(c) == idx_s1) begin
						top_q[c] <= PW'(1);
					end else if (present_q[c] && (top_q[c] < pos_s1)) begin
						top_q[c] <= top_q[c] + PW'(1);
					end
				end
			end
		end
	end

	// hold result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.commit && query_ok) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && query_ok) begin
			m_tdata_q <= OUT_TDATA_W'(pos_ext[POS_W-1:0]);
		end
	end

endmodule
